### src/rv32ie_pkg.sv
package rv32ie_pkg;

   // Data memory size in bytes, a power of two; addresses wrap at this size.
   localparam int DMEM_BYTES = 4096;
   localparam int DMEM_AW    = $clog2(DMEM_BYTES);

   // The clearing pass covers both the data memory and the register file.
   localparam int CLR_N = (DMEM_BYTES > 32) ? DMEM_BYTES : 32;
   localparam int CLR_W = $clog2(CLR_N);

   // Opcodes.
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_IMM    = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_LUI    = 7'h37;

   // The word ADDI x0,x0,1 stops the program.
   localparam logic [31:0] EXIT_WORD  = 32'h0010_0013;
   localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

   // Register-register function codes, funct7 then funct3.
   localparam logic [9:0] FN_ADD  = {7'h00, 3'd0};
   localparam logic [9:0] FN_SUB  = {7'h20, 3'd0};
   localparam logic [9:0] FN_MUL  = {7'h01, 3'd0};
   localparam logic [9:0] FN_SLL  = {7'h00, 3'd1};
   localparam logic [9:0] FN_SLT  = {7'h00, 3'd2};
   localparam logic [9:0] FN_XOR  = {7'h00, 3'd4};
   localparam logic [9:0] FN_DIV  = {7'h01, 3'd4};
   localparam logic [9:0] FN_SRL  = {7'h00, 3'd5};
   localparam logic [9:0] FN_SRA  = {7'h20, 3'd5};
   localparam logic [9:0] FN_OR   = {7'h00, 3'd6};
   localparam logic [9:0] FN_REM  = {7'h01, 3'd6};
   localparam logic [9:0] FN_AND  = {7'h00, 3'd7};

   // Immediate and branch funct3 codes.
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BYTE = 3'd0;
   localparam logic [2:0] F3_HALF = 3'd1;
   localparam logic [2:0] F3_WIDE = 3'd3;

   // Item kinds.
   localparam logic OP_EXECUTE = 1'b0;
   localparam logic OP_PRELOAD = 1'b1;

   // Memory access kinds.
   localparam logic [1:0] MACC_NONE  = 2'd0;
   localparam logic [1:0] MACC_LOAD  = 2'd1;
   localparam logic [1:0] MACC_STORE = 2'd2;

   typedef enum logic [2:0] {
      ST_EXECUTED  = 3'd0,
      ST_UNKNOWN   = 3'd1,
      ST_HALT      = 3'd2,
      ST_SELF_LOOP = 3'd3,
      ST_PRELOAD   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_READ_A,
      S_READ_B,
      S_EXEC,
      S_DIV,
      S_MEM_RD,
      S_MEM_CAP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] instruction_word;
      logic [31:0] preload_address;
      logic [7:0]  preload_byte;
   } req_type;

   typedef struct packed {
      logic [31:0]        next_pc;
      logic               register_written;
      logic [4:0]         dest_register;
      logic signed [31:0] write_value;
      logic [1:0]         memory_access;
      logic [31:0]        memory_address;
      status_type         status;
   } rsp_type;

endpackage

### src/rv32_instruction_executor_core.sv
// Channel   | Direction | Handshake           | Word
// req       | in        | req_valid/req_stall | req_type: item kind, instruction, preload
// rsp       | out       | rsp_valid/rsp_stall | rsp_type: next pc, writeback, memory, status
// csr       | in        | csr_valid/csr_ready | start_pc, also loads the program counter
//
// One item at a time under a sequencer: a preload or a halted item skips to finish;
// an ALU, branch or jump instruction first reads its two registers in turn through the
// single register file read port. Divide and remainder then run the shared restoring
// divider; loads and stores move one byte at a time on the byte-wide data memory ports.
// After reset a clearing pass over max(DMEM_BYTES, 32) addresses zeroes both memories;
// no word is taken meanwhile. A finished word waits in the output register.
module rv32_instruction_executor_core
   import rv32ie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   // Storage arrays.
   logic [31:0] rf_mem [32];
   logic [7:0]  dm_mem [DMEM_BYTES];

   // Sequencer and datapath registers.
   state_type        state_ff, state_in;
   logic [CLR_W-1:0] clr_cnt_ff, clr_cnt_in;
   req_type          item_ff, item_in;
   logic [31:0]      a_ff, a_in, b_ff, b_in;
   logic [31:0]      pc_ff, pc_in;
   logic             halted_ff, halted_in;
   rsp_type          res_ff, res_in;
   logic [31:0]      rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [4:0]       div_cnt_ff, div_cnt_in;
   logic [1:0]       byte_ff, byte_in;
   logic [31:0]      ld_ff, ld_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          out_ff, out_in;

   // Memory ports.
   logic             rf_we;
   logic [4:0]       rf_waddr, rf_raddr;
   logic [31:0]      rf_wdata, rf_q;
   logic             dm_we;
   logic [DMEM_AW-1:0] dm_waddr, dm_raddr;
   logic [7:0]       dm_wdata, dm_q;

   // Decode of the held instruction.
   logic [31:0] ins;
   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [31:0] immi, imms, immb, immj;
   logic        ex_ok, ex_dest, ex_div, ex_mem;
   logic [31:0] ex_val, ex_npc, ex_maddr;
   logic [1:0]  ex_macc, byte_last;
   logic [4:0]  sh;

   // Divider step.
   logic [32:0] div_sh, div_diff;
   logic [31:0] rem_nx, quo_nx, div_q, div_r;

   // Load assembly.
   logic [31:0] ld_word, ld_val;
   logic [DMEM_AW-1:0] mem_idx;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = out_ff;
   assign csr_ready = 1'b1;

   // Register file: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wdata;
      end
      rf_q <= rf_mem[rf_raddr];
   end

   // Data memory: one byte write port, one registered byte read port.
   always_ff @(posedge clock) begin
      if (dm_we) begin
         dm_mem[dm_waddr] <= dm_wdata;
      end
      dm_q <= dm_mem[dm_raddr];
   end

   // Field extraction and immediates.
   assign ins  = item_ff.instruction_word;
   assign opc  = ins[6:0];
   assign rd   = ins[11:7];
   assign f3   = ins[14:12];
   assign sh   = b_ff[4:0];
   assign immi = {{20{ins[31]}}, ins[31:20]};
   assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
   assign immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
   assign immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

   // Instruction decode and combinational ALU work.
   always_comb begin
      ex_ok    = 1'b1;
      ex_dest  = 1'b0;
      ex_div   = 1'b0;
      ex_mem   = 1'b0;
      ex_val   = '0;
      ex_macc  = MACC_NONE;
      ex_maddr = '0;
      ex_npc   = pc_ff + 32'd4;
      case (opc)
         OPC_OP: begin
            ex_dest = 1'b1;
            case ({ins[31:25], f3})
               FN_ADD:  ex_val = a_ff + b_ff;
               FN_SUB:  ex_val = a_ff - b_ff;
               FN_MUL:  ex_val = a_ff * b_ff;
               FN_SLL:  ex_val = a_ff << sh;
               FN_SLT:  ex_val = {31'd0, $signed(a_ff) < $signed(b_ff)};
               FN_XOR:  ex_val = a_ff ^ b_ff;
               FN_SRL:  ex_val = a_ff >> sh;
               FN_SRA:  ex_val = $unsigned($signed(a_ff) >>> sh);
               FN_OR:   ex_val = a_ff | b_ff;
               FN_AND:  ex_val = a_ff & b_ff;
               FN_DIV,
               FN_REM:  ex_div = 1'b1;
               default: ex_ok = 1'b0;
            endcase
         end
         OPC_IMM: begin
            ex_dest = 1'b1;
            case (f3)
               F3_ADD:  ex_val = a_ff + immi;
               F3_OR:   ex_val = a_ff | immi;
               F3_AND:  ex_val = a_ff & immi;
               default: ex_ok = 1'b0;
            endcase
         end
         OPC_LOAD: begin
            if (f3 > F3_WIDE) begin
               ex_ok = 1'b0;
            end else begin
               ex_dest  = 1'b1;
               ex_mem   = 1'b1;
               ex_macc  = MACC_LOAD;
               ex_maddr = a_ff + immi;
            end
         end
         OPC_STORE: begin
            if (f3 > F3_WIDE) begin
               ex_ok = 1'b0;
            end else begin
               ex_mem   = 1'b1;
               ex_macc  = MACC_STORE;
               ex_maddr = a_ff + imms;
            end
         end
         OPC_BRANCH: begin
            case (f3)
               F3_BEQ:  if (a_ff == b_ff) ex_npc = pc_ff + immb;
               F3_BNE:  if (a_ff != b_ff) ex_npc = pc_ff + immb;
               F3_BLT:  if ($signed(a_ff) < $signed(b_ff)) ex_npc = pc_ff + immb;
               F3_BGE:  if (!($signed(a_ff) < $signed(b_ff))) ex_npc = pc_ff + immb;
               default: ex_ok = 1'b0;
            endcase
         end
         OPC_JAL: begin
            ex_dest = 1'b1;
            ex_val  = pc_ff + 32'd4;
            ex_npc  = pc_ff + immj;
         end
         OPC_JALR: begin
            if (f3 != F3_ADD) begin
               ex_ok = 1'b0;
            end else begin
               ex_dest = 1'b1;
               ex_val  = pc_ff + 32'd4;
               ex_npc  = (a_ff + immi) & ~32'd1;
            end
         end
         OPC_LUI: begin
            ex_dest = 1'b1;
            ex_val  = ins & UPPER_MASK;
         end
         OPC_AUIPC: begin
            ex_dest = 1'b1;
            ex_val  = pc_ff + (ins & UPPER_MASK);
         end
         default: ex_ok = 1'b0;
      endcase
      if (!ex_ok) begin
         ex_dest  = 1'b0;
         ex_div   = 1'b0;
         ex_mem   = 1'b0;
         ex_val   = '0;
         ex_macc  = MACC_NONE;
         ex_maddr = '0;
         ex_npc   = pc_ff + 32'd4;
      end
   end

   // One restoring divide step on magnitudes, and the signed and zero-divisor fix-up of the last step.
   always_comb begin
      div_sh   = {rem_ff, quo_ff[31]};
      div_diff = div_sh - {1'b0, dvs_ff};
      quo_nx   = {quo_ff[30:0], ~div_diff[32]};
      rem_nx   = div_diff[32] ? div_sh[31:0] : div_diff[31:0];
      div_q    = (a_ff[31] != b_ff[31]) ? (32'd0 - quo_nx) : quo_nx;
      div_r    = a_ff[31] ? (32'd0 - rem_nx) : rem_nx;
      if (b_ff == 32'd0) begin
         div_q = '1;
         div_r = a_ff;
      end
   end

   // Byte lane handling for loads and stores.
   always_comb begin
      case (f3)
         F3_BYTE: byte_last = 2'd0;
         F3_HALF: byte_last = 2'd1;
         default: byte_last = 2'd3;
      endcase
      mem_idx = res_ff.memory_address[DMEM_AW-1:0] + DMEM_AW'(byte_ff);
      ld_word = ld_ff;
      ld_word[byte_ff*8 +: 8] = dm_q;
      case (f3)
         F3_BYTE: ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
         F3_HALF: ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
         default: ld_val = ld_word;
      endcase
   end

   // Sequencer: next state, register updates and memory controls.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      item_in      = item_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pc_in        = pc_ff;
      halted_in    = halted_ff;
      res_in       = res_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      div_cnt_in   = div_cnt_ff;
      byte_in      = byte_ff;
      ld_in        = ld_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rf_we        = 1'b0;
      rf_waddr     = rd;
      rf_wdata     = res_ff.write_value;
      rf_raddr     = item_ff.instruction_word[24:20];
      dm_we        = 1'b0;
      dm_waddr     = mem_idx;
      dm_wdata     = b_ff[byte_ff*8 +: 8];
      dm_raddr     = mem_idx;

      // A configuration write loads the program counter.
      if (csr_valid) begin
         pc_in = csr_data;
      end

      case (state_ff)
         S_CLEAR: begin
            rf_we      = 1'b1;
            rf_waddr   = clr_cnt_ff[4:0];
            rf_wdata   = '0;
            dm_we      = 1'b1;
            dm_waddr   = clr_cnt_ff[DMEM_AW-1:0];
            dm_wdata   = '0;
            clr_cnt_in = clr_cnt_ff + CLR_W'(1);
            if (clr_cnt_ff == CLR_W'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rf_raddr = req_data.instruction_word[19:15];
            res_in   = '0;
            res_in.next_pc = pc_ff;
            if (req_valid) begin
               item_in = req_data;
               if (req_data.operation == OP_PRELOAD) begin
                  dm_we          = 1'b1;
                  dm_waddr       = req_data.preload_address[DMEM_AW-1:0];
                  dm_wdata       = req_data.preload_byte;
                  res_in.status  = ST_PRELOAD;
                  state_in       = S_FINISH;
               end else if (halted_ff || req_data.instruction_word == EXIT_WORD) begin
                  res_in.status  = ST_HALT;
                  state_in       = S_FINISH;
               end else begin
                  state_in       = S_READ_A;
               end
            end
         end
         S_READ_A: begin
            a_in     = rf_q;
            state_in = S_READ_B;
         end
         S_READ_B: begin
            b_in     = rf_q;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res_in.next_pc          = ex_npc;
            res_in.register_written = ex_dest && (rd != 5'd0);
            res_in.dest_register    = ex_dest ? rd : 5'd0;
            res_in.write_value      = ex_val;
            res_in.memory_access    = ex_macc;
            res_in.memory_address   = ex_maddr;
            res_in.status           = ex_ok ? ST_EXECUTED : ST_UNKNOWN;
            rem_in     = '0;
            quo_in     = a_ff[31] ? (32'd0 - a_ff) : a_ff;
            dvs_in     = b_ff[31] ? (32'd0 - b_ff) : b_ff;
            div_cnt_in = '0;
            byte_in    = '0;
            ld_in      = '0;
            if (ex_div) begin
               state_in = S_DIV;
            end else if (ex_mem) begin
               state_in = S_MEM_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            rem_in     = rem_nx;
            quo_in     = quo_nx;
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               res_in.write_value = (f3 == FN_DIV[2:0]) ? div_q : div_r;
               state_in = S_FINISH;
            end
         end
         S_MEM_RD: begin
            if (res_ff.memory_access == MACC_STORE) begin
               dm_we   = 1'b1;
               byte_in = byte_ff + 2'd1;
               if (byte_ff == byte_last) begin
                  state_in = S_FINISH;
               end
            end else begin
               state_in = S_MEM_CAP;
            end
         end
         S_MEM_CAP: begin
            ld_in   = ld_word;
            byte_in = byte_ff + 2'd1;
            if (byte_ff == byte_last) begin
               res_in.write_value = ld_val;
               state_in = S_FINISH;
            end else begin
               state_in = S_MEM_RD;
            end
         end
         S_FINISH: begin
            // Wait for the output register to be free.
            if (!rsp_valid_ff || !rsp_stall) begin
               out_in = res_ff;
               if (res_ff.status == ST_EXECUTED && res_ff.next_pc == pc_ff) begin
                  out_in.status = ST_SELF_LOOP;
               end
               rsp_valid_in = 1'b1;
               rf_we        = res_ff.register_written;
               pc_in        = res_ff.next_pc;
               halted_in    = halted_ff || out_in.status == ST_HALT ||
                              out_in.status == ST_SELF_LOOP;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pc_ff        <= pc_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      res_ff     <= res_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      dvs_ff     <= dvs_in;
      div_cnt_ff <= div_cnt_in;
      byte_ff    <= byte_in;
      ld_ff      <= ld_in;
      out_ff     <= out_in;
   end

endmodule

### src/rv32ie_checker.sv
module rv32ie_checker
   import rv32ie_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A waiting result word stays.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word dropped or changed while stalled");

   // The block holds off new words right after taking one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("word taken while the previous one is in work");

   // A written register is never x0.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.register_written |-> rsp_data.dest_register != 5'd0)
      else $error("write reported for x0");

   // Preloads, halts and unknown words touch nothing else.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_PRELOAD || rsp_data.status == ST_HALT ||
                    rsp_data.status == ST_UNKNOWN)
      |-> !rsp_data.register_written && rsp_data.memory_access == MACC_NONE)
      else $error("side effect reported for a non-executing word");

endmodule

bind rv32_instruction_executor_core rv32ie_checker u_rv32ie_checker (.*);

### bench/rv32_instruction_executor_core_tb.sv
module rv32_instruction_executor_core_tb;
   import rv32ie_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int PHASE_ITEMS = 340;

   localparam logic [9:0] FN_LIST [12] = '{FN_ADD, FN_SUB, FN_MUL, FN_SLL, FN_SLT, FN_XOR,
                                          FN_DIV, FN_SRL, FN_SRA, FN_OR, FN_REM, FN_AND};
   localparam logic [2:0] F3_WORD = 3'd2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   // Architectural state kept alongside the core.
   logic [31:0] arch_pc = '0;
   logic [31:0] arch_gpr [32];
   logic [7:0]  arch_dmem [DMEM_BYTES];
   bit          arch_halted = 1'b0;

   rsp_type     pending_rsp [$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          rsp_hold = 0;
   bit          calm = 1'b0;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   stim_row_type directed_rows [$];

   rv32_instruction_executor_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      foreach (arch_gpr[i]) arch_gpr[i] = '0;
      foreach (arch_dmem[i]) arch_dmem[i] = '0;
   end

   // Instruction encoders.
   function automatic logic [31:0] r_word(logic [9:0] fn, logic [4:0] rd, logic [4:0] rs1,
                                          logic [4:0] rs2);
      return {fn[9:3], rs2, rs1, fn[2:0], rd, OPC_OP};
   endfunction

   function automatic logic [31:0] i_word(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                          logic [4:0] rs1, logic [11:0] imm);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] s_word(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [11:0] imm);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
   endfunction

   function automatic logic [31:0] b_word(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                          logic [12:0] off);
      return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
   endfunction

   function automatic logic [31:0] j_word(logic [4:0] rd, logic [20:0] off);
      return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
   endfunction

   function automatic logic [31:0] u_word(logic [6:0] opc, logic [4:0] rd, logic [19:0] imm);
      return {imm, rd, opc};
   endfunction

   function automatic req_type exec_req(logic [31:0] word);
      req_type r;
      r = '0;
      r.operation = OP_EXECUTE;
      r.instruction_word = word;
      return r;
   endfunction

   function automatic req_type preload_req(logic [31:0] addr, logic [7:0] data);
      req_type r;
      r = '0;
      r.operation = OP_PRELOAD;
      r.preload_address = addr;
      r.preload_byte = data;
      return r;
   endfunction

   // Signed divide with the RISC-V rules for zero divisors and overflow.
   function automatic void rv_divide(logic [31:0] a, logic [31:0] b, output logic [31:0] quo,
                                     output logic [31:0] rem);
      if (b == '0) begin
         quo = '1;
         rem = a;
      end else if (a == 32'h8000_0000 && b == '1) begin
         quo = a;
         rem = '0;
      end else begin
         quo = $signed(a) / $signed(b);
         rem = $signed(a) % $signed(b);
      end
   endfunction

   // Works out the result word of one item; the state is updated only when commit is set.
   function automatic rsp_type execute_item(req_type r, bit commit);
      rsp_type     o;
      logic [31:0] ins, pc, npc, a, b, immi, val, maddr, quo, rem;
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic [9:0]  fn;
      logic [1:0]  macc;
      status_type  st;
      bit          dest, ok, take;
      int          nbytes;
      ins = r.instruction_word;
      pc = arch_pc;
      npc = pc + 32'd4;
      rd = ins[11:7];
      f3 = ins[14:12];
      fn = {ins[31:25], f3};
      a = arch_gpr[ins[19:15]];
      b = arch_gpr[ins[24:20]];
      immi = {{20{ins[31]}}, ins[31:20]};
      val = '0;
      maddr = '0;
      macc = MACC_NONE;
      st = ST_EXECUTED;
      dest = 1'b0;
      ok = 1'b1;
      take = 1'b0;
      if (r.operation == OP_PRELOAD) begin
         if (commit) arch_dmem[r.preload_address[DMEM_AW-1:0]] = r.preload_byte;
         npc = pc;
         st = ST_PRELOAD;
      end else if (arch_halted) begin
         npc = pc;
         st = ST_HALT;
      end else if (ins == EXIT_WORD) begin
         npc = pc;
         st = ST_HALT;
         if (commit) arch_halted = 1'b1;
      end else begin
         case (ins[6:0])
            OPC_OP: begin
               dest = 1'b1;
               rv_divide(a, b, quo, rem);
               case (fn)
                  FN_ADD: val = a + b;
                  FN_SUB: val = a - b;
                  FN_MUL: val = a * b;
                  FN_SLL: val = a << b[4:0];
                  FN_SLT: val = {31'd0, $signed(a) < $signed(b)};
                  FN_XOR: val = a ^ b;
                  FN_DIV: val = quo;
                  FN_SRL: val = a >> b[4:0];
                  FN_SRA: val = $signed(a) >>> b[4:0];
                  FN_OR:  val = a | b;
                  FN_REM: val = rem;
                  FN_AND: val = a & b;
                  default: ok = 1'b0;
               endcase
            end
            OPC_IMM: begin
               dest = 1'b1;
               case (f3)
                  F3_ADD: val = a + immi;
                  F3_OR:  val = a | immi;
                  F3_AND: val = a & immi;
                  default: ok = 1'b0;
               endcase
            end
            OPC_LOAD: begin
               if (f3 > F3_WIDE) begin
                  ok = 1'b0;
               end else begin
                  dest = 1'b1;
                  macc = MACC_LOAD;
                  maddr = a + immi;
                  for (int i = 0; i < 4; i++)
                     val[8*i +: 8] = arch_dmem[DMEM_AW'(maddr + 32'(i))];
                  if (f3 == F3_BYTE) val = {{24{val[7]}}, val[7:0]};
                  else if (f3 == F3_HALF) val = {{16{val[15]}}, val[15:0]};
               end
            end
            OPC_STORE: begin
               if (f3 > F3_WIDE) begin
                  ok = 1'b0;
               end else begin
                  macc = MACC_STORE;
                  maddr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                  nbytes = (f3 == F3_BYTE) ? 1 : (f3 == F3_HALF) ? 2 : 4;
                  if (commit)
                     for (int i = 0; i < nbytes; i++)
                        arch_dmem[DMEM_AW'(maddr + 32'(i))] = b[8*i +: 8];
               end
            end
            OPC_BRANCH: begin
               case (f3)
                  F3_BEQ: take = (a == b);
                  F3_BNE: take = (a != b);
                  F3_BLT: take = $signed(a) < $signed(b);
                  F3_BGE: take = $signed(a) >= $signed(b);
                  default: ok = 1'b0;
               endcase
               if (take)
                  npc = pc + {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            end
            OPC_JAL: begin
               dest = 1'b1;
               val = pc + 32'd4;
               npc = pc + {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
            end
            OPC_JALR: begin
               if (f3 != 3'd0) begin
                  ok = 1'b0;
               end else begin
                  dest = 1'b1;
                  val = pc + 32'd4;
                  npc = (a + immi) & ~32'd1;
               end
            end
            OPC_LUI: begin
               dest = 1'b1;
               val = ins & UPPER_MASK;
            end
            OPC_AUIPC: begin
               dest = 1'b1;
               val = pc + (ins & UPPER_MASK);
            end
            default: ok = 1'b0;
         endcase
         if (!ok) begin
            dest = 1'b0;
            val = '0;
            macc = MACC_NONE;
            maddr = '0;
            npc = pc + 32'd4;
            st = ST_UNKNOWN;
         end else begin
            if (commit && dest && rd != 5'd0) arch_gpr[rd] = val;
            if (npc == pc) begin
               st = ST_SELF_LOOP;
               if (commit) arch_halted = 1'b1;
            end
         end
         if (commit) arch_pc = npc;
      end
      o.next_pc = npc;
      o.register_written = dest && rd != 5'd0;
      o.dest_register = dest ? rd : 5'd0;
      o.write_value = val;
      o.memory_access = macc;
      o.memory_address = maddr;
      o.status = st;
      return o;
   endfunction

   // Random item: mostly well-formed instructions, some preloads, noise and bad encodings.
   function automatic req_type random_item();
      req_type     r;
      logic [31:0] w;
      logic [2:0]  f3;
      logic [9:0]  fn;
      int          pick;
      r.operation = OP_EXECUTE;
      r.instruction_word = $urandom;
      r.preload_address = $urandom;
      r.preload_byte = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         r.operation = OP_PRELOAD;
         return r;
      end
      if (pick < 16) return r;
      w = r.instruction_word;
      f3 = ($urandom_range(0, 7) == 0) ? w[14:12] : 3'($urandom_range(0, 3));
      fn = ($urandom_range(0, 7) == 0) ? w[31:22] : FN_LIST[$urandom_range(0, 11)];
      case ($urandom_range(0, 9))
         0, 1: w = r_word(fn, w[11:7], w[19:15], w[24:20]);
         2: w = i_word(OPC_IMM, ($urandom_range(0, 1)) ? F3_ADD : w[13] ? F3_OR : F3_AND,
                       w[11:7], w[19:15], w[31:20]);
         3: w = u_word(w[0] ? OPC_LUI : OPC_AUIPC, w[11:7], w[31:12]);
         4, 5: w = i_word(OPC_LOAD, f3, w[11:7], w[19:15], w[31:20]);
         6: w = s_word(f3, w[19:15], w[24:20], w[31:20]);
         7: w = b_word(w[13] ? (w[14] ? F3_BGE : F3_BLT) : (w[12] ? F3_BNE : F3_BEQ),
                       w[19:15], w[24:20], {w[31:20], 1'b0});
         8: w = j_word(w[11:7], {w[31:12], 1'b0});
         default: w = i_word(OPC_JALR, 3'd0, w[11:7], w[19:15], w[31:20]);
      endcase
      r.instruction_word = w;
      return r;
   endfunction

   // Sends one word after a random gap (none in the calm phase); the expected result is queued first.
   task automatic send_word(req_type r, bit typed, rsp_type fixed);
      rsp_type p;
      int      gap;
      p = execute_item(r, 1'b1);
      pending_rsp.insert(pending_rsp.size(), typed ? fixed : p);
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Writes start_pc once the core is idle; it also reloads the program counter.
   task automatic write_start_pc(logic [31:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      arch_pc = value;
   endtask

   // Directed rows; the first three are known at a glance from a start_pc of zero.
   function automatic void add_row(req_type r);
      directed_rows.insert(directed_rows.size(), '{req: r, typed: 1'b0, rsp: '0});
   endfunction

   function automatic void build_directed();
      directed_rows.insert(directed_rows.size(),
         '{req: exec_req(i_word(OPC_IMM, F3_ADD, 5'd1, 5'd0, 12'hFFF)),
         typed: 1'b1, rsp: '{next_pc: 32'd4, register_written: 1'b1, dest_register: 5'd1,
         write_value: -32'sd1, memory_access: MACC_NONE, memory_address: '0,
         status: ST_EXECUTED}});
      directed_rows.insert(directed_rows.size(),
         '{req: exec_req({25'h155_5555, 7'h7F}), typed: 1'b1,
         rsp: '{next_pc: 32'd8, register_written: 1'b0, dest_register: 5'd0,
         write_value: '0, memory_access: MACC_NONE, memory_address: '0,
         status: ST_UNKNOWN}});
      directed_rows.insert(directed_rows.size(),
         '{req: preload_req(32'hFFFF_FFFF, 8'hA5), typed: 1'b1,
         rsp: '{next_pc: 32'd8, register_written: 1'b0, dest_register: 5'd0,
         write_value: '0, memory_access: MACC_NONE, memory_address: '0,
         status: ST_PRELOAD}});
      add_row(exec_req(u_word(OPC_LUI, 5'd2, 20'h80000)));
      // Overflow and divide-by-zero cases.
      add_row(exec_req(r_word(FN_DIV, 5'd3, 5'd2, 5'd1)));
      add_row(exec_req(r_word(FN_REM, 5'd4, 5'd2, 5'd1)));
      add_row(exec_req(r_word(FN_DIV, 5'd5, 5'd1, 5'd0)));
      add_row(exec_req(r_word(FN_REM, 5'd6, 5'd2, 5'd0)));
      // Shifts by 31, which only the low five bits of rs2 give.
      add_row(exec_req(r_word(FN_SRA, 5'd7, 5'd2, 5'd1)));
      add_row(exec_req(r_word(FN_SRL, 5'd8, 5'd2, 5'd1)));
      add_row(exec_req(r_word(FN_SLL, 5'd0, 5'd1, 5'd1)));
      add_row(exec_req(r_word(FN_SLT, 5'd10, 5'd2, 5'd1)));
      add_row(exec_req(r_word(FN_MUL, 5'd11, 5'd1, 5'd1)));
      add_row(exec_req(r_word(FN_ADD, 5'd12, 5'd1, 5'd2)));
      add_row(exec_req(r_word(FN_SUB, 5'd13, 5'd0, 5'd2)));
      add_row(exec_req(r_word(FN_XOR, 5'd14, 5'd12, 5'd2)));
      add_row(exec_req(r_word(FN_OR, 5'd15, 5'd8, 5'd2)));
      add_row(exec_req(r_word(FN_AND, 5'd16, 5'd1, 5'd12)));
      add_row(exec_req(i_word(OPC_IMM, F3_OR, 5'd17, 5'd0, 12'h7FF)));
      add_row(exec_req(i_word(OPC_IMM, F3_AND, 5'd18, 5'd1, 12'h800)));
      // Accesses across the end of memory wrap to the start.
      add_row(exec_req(s_word(F3_WORD, 5'd1, 5'd12, 12'h000)));
      add_row(exec_req(s_word(F3_BYTE, 5'd0, 5'd1, 12'h7FF)));
      add_row(exec_req(s_word(F3_WIDE, 5'd1, 5'd17, 12'hFFD)));
      add_row(exec_req(i_word(OPC_LOAD, F3_BYTE, 5'd19, 5'd1, 12'h000)));
      add_row(exec_req(i_word(OPC_LOAD, F3_HALF, 5'd20, 5'd1, 12'hFFF)));
      add_row(exec_req(i_word(OPC_LOAD, F3_WORD, 5'd21, 5'd1, 12'hFFE)));
      add_row(exec_req(i_word(OPC_LOAD, F3_WIDE, 5'd22, 5'd0, 12'h7FF)));
      add_row(exec_req(b_word(F3_BEQ, 5'd0, 5'd0, 13'h1FF8)));
      add_row(exec_req(b_word(F3_BNE, 5'd1, 5'd0, 13'h0FFE)));
      add_row(exec_req(b_word(F3_BLT, 5'd2, 5'd1, 13'h1000)));
      add_row(exec_req(b_word(F3_BGE, 5'd1, 5'd2, 13'h0010)));
      add_row(exec_req(b_word(3'd2, 5'd1, 5'd2, 13'h0010)));
      add_row(exec_req(j_word(5'd1, 21'h1FF800)));
      add_row(exec_req(i_word(OPC_JALR, 3'd0, 5'd23, 5'd1, 12'h7FF)));
      add_row(exec_req(u_word(OPC_AUIPC, 5'd24, 20'hFFFFF)));
   endfunction

   // Result side: random stall per word, checked against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_hold = calm ? 0 : $urandom_range(0, 19);
            if (pending_rsp.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("Unexpected result word %h", rsp_data);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data !== want) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display({"Result mismatch: expected pc=%h wr=%b rd=%0d val=%h ",
                               "acc=%0d addr=%h st=%0d, got pc=%h wr=%b rd=%0d val=%h ",
                               "acc=%0d addr=%h st=%0d"},
                        want.next_pc, want.register_written, want.dest_register,
                        want.write_value, want.memory_access, want.memory_address,
                        want.status, rsp_data.next_pc, rsp_data.register_written,
                        rsp_data.dest_register, rsp_data.write_value,
                        rsp_data.memory_access, rsp_data.memory_address, rsp_data.status);
               end
            end
         end else if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [31:0] start_values [5];
      req_type     r;
      rsp_type     none;
      rsp_type     probe;
      none = '0;
      start_values = '{32'hFFFF_FFFC, 32'h0000_0000, $urandom, 32'hFFFF_FFFF, $urandom};
      build_directed();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part from a start_pc of zero.
      write_start_pc(32'h0);
      foreach (directed_rows[i])
         send_word(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      // Random phases, each under its own start_pc; one runs without random gaps or result stalls.
      for (int ph = 0; ph < 5; ph++) begin
         write_start_pc(start_values[ph]);
         calm = (ph == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Halting is kept for the end, since nothing but reset clears it.
            do begin
               r = random_item();
               probe = execute_item(r, 1'b0);
            end while (r.operation == OP_EXECUTE &&
                       probe.status inside {ST_HALT, ST_SELF_LOOP});
            if (n == PHASE_ITEMS / 2) wait_drained();
            send_word(r, 1'b0, none);
         end
      end
      calm = 1'b0;

      // Halt by either the exit word or a self-jump, then items while halted.
      if ($urandom_range(0, 1)) send_word(exec_req(EXIT_WORD), 1'b0, none);
      else send_word(exec_req(j_word(5'd5, 21'd0)), 1'b0, none);
      for (int n = 0; n < 6; n++) send_word(random_item(), 1'b0, none);
      send_word(exec_req(i_word(OPC_LOAD, F3_WORD, 5'd9, 5'd0, 12'hFFF)), 1'b0, none);

      wait_drained();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### rv32_instruction_executor_core.f
src/rv32ie_pkg.sv
src/rv32_instruction_executor_core.sv
src/rv32ie_checker.sv
bench/rv32_instruction_executor_core_tb.sv
